// ===== rtl/core/lga_pkg.sv =====
package lga_pkg;

  localparam int ProbBits  = 17;
  localparam int CountBits = 16;
  localparam int AccBits   = 48;

  typedef enum logic [1:0] {
    CFG_COMP_A = 2'd0,
    CFG_COMP_C = 2'd1,
    CFG_COMP_G = 2'd2,
    CFG_COMP_T = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ProbBits-1:0]  prob_a;
    logic [ProbBits-1:0]  prob_c;
    logic [ProbBits-1:0]  prob_g;
    logic [ProbBits-1:0]  prob_t;
    logic [CountBits-1:0] obs_count;
    logic                 last_item;
  } in_item_t;

  typedef struct packed {
    logic [AccBits-1:0] grad_a;
    logic [AccBits-1:0] grad_c;
    logic [AccBits-1:0] grad_g;
    logic [AccBits-1:0] grad_t;
    logic               sat_flag;
    logic               zero_dot_flag;
  } out_item_t;

endpackage

// ===== rtl/core/lga_front.sv =====
// Front part: accumulates the dot product over the four components in turn and queues the record.
module lga_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  lga_pkg::in_item_t      in_data,
  input  logic [16:0]            comp_a,
  input  logic [16:0]            comp_c,
  input  logic [16:0]            comp_g,
  input  logic [16:0]            comp_t,
  output logic                   q_valid,
  output lga_pkg::in_item_t      q_item,
  output logic [35:0]            q_dot,
  input  logic                   q_take
);
  import lga_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_HOLD} fstate_t;

  fstate_t     state_r;
  in_item_t    item_r;
  logic [35:0] dot_r;
  logic [1:0]  k_r;
  logic [16:0] p_sel, c_sel;
  logic [33:0] prod;

  always_comb begin
    case (k_r)
      2'd0:    begin p_sel = item_r.prob_a; c_sel = comp_a; end
      2'd1:    begin p_sel = item_r.prob_c; c_sel = comp_c; end
      2'd2:    begin p_sel = item_r.prob_g; c_sel = comp_g; end
      default: begin p_sel = item_r.prob_t; c_sel = comp_t; end
    endcase
    prod = p_sel * c_sel;
  end

  assign in_full = (state_r != F_IDLE);
  assign q_valid = (state_r == F_HOLD);
  assign q_item  = item_r;
  assign q_dot   = dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      k_r     <= '0;
    end else begin
      case (state_r)
        F_IDLE: if (in_push) begin
          item_r  <= in_data;
          dot_r   <= '0;
          k_r     <= '0;
          state_r <= F_MUL;
        end
        F_MUL: begin
          dot_r <= dot_r + 36'(prod);
          k_r   <= k_r + 2'd1;
          if (k_r == 2'd3) state_r <= F_HOLD;
        end
        F_HOLD: if (q_take) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/lga_back.sv =====
// Back part: restoring division of count*p*2^32 by the dot product, one
// quotient bit per cycle, four components in turn, each accumulated after its division.
module lga_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  lga_pkg::in_item_t      q_item,
  input  logic [35:0]            q_dot,
  output logic                   q_take,
  output logic                   out_empty,
  input  logic                   out_pop,
  output lga_pkg::out_item_t     out_data
);
  import lga_pkg::*;

  localparam int NumBits = 33 + 32;  // numerator bits: count*p (33) scaled by 2^32

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_ACC, B_OUT} bstate_t;

  bstate_t            state_r;
  in_item_t           item_r;
  logic [35:0]        den_r;
  logic [1:0]         k_r;
  logic [6:0]         bit_r;
  logic [NumBits-1:0] num_r;
  logic [36:0]        rem_r;
  logic [AccBits-1:0] quo_r;
  logic               big_r;
  logic [AccBits-1:0] acc_r [4];
  logic               sat_r, zero_r;
  out_item_t          res_r;

  logic [36:0]        rem_sh;
  logic               ge;
  logic [36:0]        rem_nxt;
  logic [AccBits:0]   quo_sh;
  logic [AccBits-1:0] term;
  logic [AccBits:0]   sum;

  function automatic logic [32:0] numer_next(in_item_t it, logic [1:0] k);
    logic [16:0] p;
    case (k)
      2'd0:    p = it.prob_a;
      2'd1:    p = it.prob_c;
      2'd2:    p = it.prob_g;
      default: p = it.prob_t;
    endcase
    return 33'(it.obs_count) * 33'(p);
  endfunction

  always_comb begin
    rem_sh  = {rem_r[35:0], num_r[NumBits-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
    quo_sh  = {quo_r, ge};
    term    = big_r ? '1 : quo_r;
    sum     = {1'b0, acc_r[k_r]} + {1'b0, term};
  end

  assign q_take    = (state_r == B_IDLE) && q_valid;
  assign out_empty = (state_r != B_OUT);
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      sat_r   <= 1'b0;
      zero_r  <= 1'b0;
      k_r     <= '0;
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
    end else begin
      case (state_r)
        B_IDLE: if (q_valid) begin
          item_r <= q_item;
          den_r  <= q_dot;
          if (q_dot == '0) begin
            zero_r <= 1'b1;
            state_r <= B_ACC;
            k_r <= 2'd3;
            big_r <= 1'b0;
            quo_r <= '0;
          end else begin
            state_r <= B_DIV;
            k_r     <= '0;
            bit_r   <= '0;
            rem_r   <= '0;
            quo_r   <= '0;
            big_r   <= 1'b0;
            num_r   <= {numer_next(q_item, 2'd0), 32'd0};
          end
        end
        B_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_sh[AccBits-1:0];
          if (quo_sh[AccBits]) big_r <= 1'b1;
          num_r <= num_r << 1;
          bit_r <= bit_r + 7'd1;
          if (bit_r == 7'(NumBits - 1)) state_r <= B_ACC;
        end
        B_ACC: begin
          if (k_r == 2'd3 && item_r.last_item) begin
            res_r.grad_a <= acc_r[0];
            res_r.grad_c <= acc_r[1];
            res_r.grad_g <= acc_r[2];
            res_r.grad_t <= (den_r != '0) ? (sum[AccBits] ? '1 : sum[AccBits-1:0])
                                          : acc_r[3];
            res_r.sat_flag      <= sat_r | ((den_r != '0) & (big_r | sum[AccBits]));
            res_r.zero_dot_flag <= zero_r;
            for (int i = 0; i < 4; i++) acc_r[i] <= '0;
            sat_r  <= 1'b0;
            zero_r <= 1'b0;
            state_r <= B_OUT;
          end else begin
            if (den_r != '0) begin
              if (big_r || sum[AccBits]) sat_r <= 1'b1;
              acc_r[k_r] <= sum[AccBits] ? '1 : sum[AccBits-1:0];
            end
            if (k_r == 2'd3) begin
              state_r <= B_IDLE;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= B_DIV;
              bit_r   <= '0;
              rem_r   <= '0;
              quo_r   <= '0;
              big_r   <= 1'b0;
              num_r   <= {numer_next(item_r, k_r + 2'd1), 32'd0};
            end
          end
        end
        B_OUT: if (out_pop) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/likelihood_gradient_accumulator.sv =====
// Channel   Ports                          Direction
// input     in_push, in_full, in_data      record in
// result    out_empty, out_pop, out_data   gradient sums out
// config    cfg_we, cfg_idx, cfg_wdata     composition write
//
// A record passes through the dot-product unit and then the back part, whose
// restoring divider yields one quotient bit per cycle for each component.
// A record with a zero dot product skips the divider.
// Reset is synchronous; it clears the sums and sets each fraction to 0.25.
// The front part takes the next record while the back part is still dividing;
// a waiting result holds the back part, and then the front part fills up.
module likelihood_gradient_accumulator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  lga_pkg::in_item_t   in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output lga_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [16:0]         cfg_wdata
);
  import lga_pkg::*;

  logic [16:0] comp_r [4];
  logic        q_valid, q_take;
  in_item_t    q_item;
  logic [35:0] q_dot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) comp_r[i] <= 17'd16384;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_COMP_A: comp_r[0] <= cfg_wdata;
        CFG_COMP_C: comp_r[1] <= cfg_wdata;
        CFG_COMP_G: comp_r[2] <= cfg_wdata;
        CFG_COMP_T: comp_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lga_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .comp_a(comp_r[0]), .comp_c(comp_r[1]), .comp_g(comp_r[2]), .comp_t(comp_r[3]),
    .q_valid, .q_item, .q_dot, .q_take
  );

  lga_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_dot, .q_take,
    .out_empty, .out_pop, .out_data
  );
endmodule

// ===== tb/tb_likelihood_gradient_accumulator.sv =====
module tb_likelihood_gradient_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import lga_pkg::*;

  localparam int FracBits = ProbBits - 1;
  localparam logic [AccBits-1:0] AccMax = '1;
  localparam int SettleCycles = 600;
  localparam longint CycleLimit = 4000000;
  localparam int Phases = 8;
  localparam int RecordsPerPhase = 225;
  localparam int HoldCycles = 20000;

  typedef struct {
    int        grp;
    in_item_t  rec;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  logic [16:0] cfg_wdata;

  // Predictor state: composition, accumulators and sticky flags.
  logic [ProbBits-1:0] comp_w[4];
  logic [AccBits-1:0]  grad_acc[4];
  bit                  sat_seen;
  bit                  zero_seen;

  out_item_t grad_q[$];
  cfg_idx_t  idx_names[4] = '{CFG_COMP_A, CFG_COMP_C, CFG_COMP_G, CFG_COMP_T};

  int     errors = 0;
  int     records_sent = 0;
  int     sums_seen = 0;
  int     sat_results = 0;
  int     zero_results = 0;
  longint cycles = 0;
  bit     burst = 0;
  bit     hold_req = 0;
  bit     hold_done = 0;
  int     hold_left = 0;

  likelihood_gradient_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic in_item_t rec(logic [16:0] a, logic [16:0] c, logic [16:0] g,
                                   logic [16:0] t, logic [15:0] cnt, logic last);
    in_item_t r;
    r.prob_a = a;
    r.prob_c = c;
    r.prob_g = g;
    r.prob_t = t;
    r.obs_count = cnt;
    r.last_item = last;
    return r;
  endfunction

  function automatic out_item_t sums(logic [47:0] a, logic [47:0] c, logic [47:0] g,
                                     logic [47:0] t, logic s, logic z);
    out_item_t r;
    r.grad_a = a;
    r.grad_c = c;
    r.grad_g = g;
    r.grad_t = t;
    r.sat_flag = s;
    r.zero_dot_flag = z;
    return r;
  endfunction

  // Accumulates one record; a record marked last yields the sums and clears the state.
  function automatic void accumulate_record(input in_item_t it, output bit emit,
                                            output out_item_t res);
    logic [ProbBits-1:0] p[4];
    logic [63:0]         dot;
    logic [127:0]        quo;
    logic [AccBits-1:0]  term;
    logic [AccBits:0]    total;
    p[0] = it.prob_a;
    p[1] = it.prob_c;
    p[2] = it.prob_g;
    p[3] = it.prob_t;
    dot = 0;
    for (int i = 0; i < 4; i++) dot += 64'(p[i]) * 64'(comp_w[i]);
    if (dot == 0) begin
      zero_seen = 1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        quo = ((128'(it.obs_count) * 128'(p[i])) << (2 * FracBits)) / 128'(dot);
        if (quo > 128'(AccMax)) begin
          term = AccMax;
          sat_seen = 1;
        end else begin
          term = quo[AccBits-1:0];
        end
        total = {1'b0, grad_acc[i]} + {1'b0, term};
        if (total[AccBits]) begin
          grad_acc[i] = AccMax;
          sat_seen = 1;
        end else begin
          grad_acc[i] = total[AccBits-1:0];
        end
      end
    end
    emit = it.last_item;
    res = sums(grad_acc[0], grad_acc[1], grad_acc[2], grad_acc[3], sat_seen, zero_seen);
    if (emit) begin
      for (int i = 0; i < 4; i++) grad_acc[i] = '0;
      sat_seen = 0;
      zero_seen = 0;
    end
  endfunction

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic push_record(in_item_t it, bit typed, out_item_t typed_res);
    bit        emit;
    out_item_t res;
    if (!burst) begin
      while ($urandom_range(99) < 34) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    end
    in_data <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    accumulate_record(it, emit, res);
    if (emit) grad_q.push_back(typed ? typed_res : res);
    records_sent++;
  endtask

  // A record that yields no sums may still be dividing, so wait well past the last one.
  task automatic settle();
    in_push <= 1'b0;
    while (grad_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_comp(logic [16:0] v[4]);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx_names[i];
      cfg_wdata <= v[i];
      comp_w[i] = v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [16:0] pick_prob();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1ffff;
      3: return 17'd1;
      default: return 17'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    stim_row_t   rows[$];
    logic [16:0] comp_dir[3][4];
    logic [16:0] v[4];
    out_item_t   none;
    int          grp;
    none = '0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_COMP_A;
    cfg_wdata = '0;
    for (int i = 0; i < 4; i++) begin
      comp_w[i] = 17'd16384;
      grad_acc[i] = '0;
    end
    comp_dir[0] = '{17'd16384, 17'd16384, 17'd16384, 17'd16384};
    comp_dir[1] = '{17'd1, 17'd0, 17'd0, 17'd0};
    comp_dir[2] = '{17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff};

    // Reset composition: a quarter each.
    rows.push_back('{0, rec(17'd65536, 17'd65536, 17'd65536, 17'd65536, 16'd1, 1'b1), 1,
                     sums(48'd65536, 48'd65536, 48'd65536, 48'd65536, 1'b0, 1'b0)});
    rows.push_back('{0, rec(17'd0, 17'd0, 17'd0, 17'd0, 16'hffff, 1'b1), 1,
                     sums(48'd0, 48'd0, 48'd0, 48'd0, 1'b0, 1'b1)});
    rows.push_back('{0, rec(17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff, 16'hffff, 1'b0), 0,
                     none});
    rows.push_back('{0, rec(17'd1, 17'd0, 17'd0, 17'd0, 16'd0, 1'b1), 0, none});
    rows.push_back('{0, rec(17'd65536, 17'd0, 17'd0, 17'd0, 16'hffff, 1'b1), 1,
                     sums(48'd17179607040, 48'd0, 48'd0, 48'd0, 1'b0, 1'b0)});
    rows.push_back('{0, rec(17'd65535, 17'd32768, 17'd12345, 17'd99999, 16'd777, 1'b1), 0,
                     none});
    // Tiny composition: a term too large for the sum, then sums that overflow.
    rows.push_back('{1, rec(17'd1, 17'h1ffff, 17'd0, 17'd0, 16'hffff, 1'b1), 1,
                     sums(48'hffff_0000_0000, AccMax, 48'd0, 48'd0, 1'b1, 1'b0)});
    rows.push_back('{1, rec(17'd0, 17'd5, 17'd0, 17'd0, 16'd9, 1'b1), 1,
                     sums(48'd0, 48'd0, 48'd0, 48'd0, 1'b0, 1'b1)});
    rows.push_back('{1, rec(17'd1, 17'd0, 17'd0, 17'd0, 16'hffff, 1'b0), 0, none});
    rows.push_back('{1, rec(17'd1, 17'd0, 17'd0, 17'd0, 16'hffff, 1'b0), 0, none});
    rows.push_back('{1, rec(17'd1, 17'd0, 17'd0, 17'd0, 16'd0, 1'b1), 1,
                     sums(AccMax, 48'd0, 48'd0, 48'd0, 1'b1, 1'b0)});
    // Largest composition, values above one throughout.
    rows.push_back('{2, rec(17'h1ffff, 17'd1, 17'd65536, 17'd0, 16'hffff, 1'b0), 0, none});
    rows.push_back('{2, rec(17'h10000, 17'h0ffff, 17'h1ffff, 17'd3, 16'd1, 1'b0), 0, none});
    rows.push_back('{2, rec(17'd0, 17'd0, 17'd0, 17'd0, 16'd5, 1'b1), 0, none});
    rows.push_back('{2, rec(17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff, 16'hffff, 1'b1), 0,
                     none});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    grp = -1;
    foreach (rows[r]) begin
      if (rows[r].grp != grp) begin
        grp = rows[r].grp;
        settle();
        v = comp_dir[grp];
        write_comp(v);
      end
      push_record(rows[r].rec, rows[r].typed, rows[r].res);
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      for (int i = 0; i < 4; i++) begin
        case (ph % 5)
          0: v[i] = 17'($urandom);
          1: v[i] = 17'h1ffff;
          2: v[i] = 17'd0;
          3: v[i] = 17'd16384;
          default: v[i] = (i == ph % 4) ? 17'd0 : 17'($urandom_range(65536));
        endcase
      end
      write_comp(v);
      if (ph == 1) hold_req <= 1'b1;
      burst <= (ph == 3);
      for (int n = 0; n < RecordsPerPhase; n++) begin
        push_record(rec(pick_prob(), pick_prob(), pick_prob(), pick_prob(), pick_count(),
                        $urandom_range(7) == 0), 0, none);
      end
    end
    settle();

    $display("Sent %0d records over %0d composition settings; checked %0d sums,",
             records_sent, Phases + 3, sums_seen);
    $display("of which %0d saturated and %0d had a zero dot product.",
             sat_results, zero_results);
    if (errors == 0) begin
      $display("tb_likelihood_gradient_accumulator: clean");
    end else begin
      $display("tb_likelihood_gradient_accumulator: errors");
    end
    $finish;
  end

  // Receiver: checks each popped transaction, idles at random and holds off once.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (grad_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
          errors++;
        end else begin
          want = grad_q.pop_front();
          check_field("grad_a", want.grad_a, out_data.grad_a);
          check_field("grad_c", want.grad_c, out_data.grad_c);
          check_field("grad_g", want.grad_g, out_data.grad_g);
          check_field("grad_t", want.grad_t, out_data.grad_t);
          check_field("sat_flag", 48'(want.sat_flag), 48'(out_data.sat_flag));
          check_field("zero_dot_flag", 48'(want.zero_dot_flag), 48'(out_data.zero_dot_flag));
          sums_seen++;
          if (out_data.sat_flag) sat_results++;
          if (out_data.zero_dot_flag) zero_results++;
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= burst || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d sums outstanding", cycles, grad_q.size());
      $display("tb_likelihood_gradient_accumulator: errors");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/lga_pkg.sv
rtl/core/lga_front.sv
rtl/core/lga_back.sv
rtl/core/likelihood_gradient_accumulator.sv
tb/tb_likelihood_gradient_accumulator.sv
